>>> rtl/core/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types and constants for the ultrasonic ranger sequencer.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int SENSOR_COUNT = 4;

  localparam logic [1:0]  LAST_SENSOR    = 2'(SENSOR_COUNT - 1);
  localparam logic [16:0] PAUSE_TICKS    = 17'd10;
  localparam logic [16:0] TRIG_LOW_TICKS = 17'd2;
  localparam logic [8:0]  SOUND_NUM      = 9'd343;

  localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd10;
  localparam logic [15:0] SETTLE_LIMIT_RST  = 16'd5000;
  localparam logic [15:0] START_LIMIT_RST   = 16'd5000;
  localparam logic [15:0] ECHO_LIMIT_RST    = 16'd25000;
  localparam logic [15:0] GAP_LENGTH_RST    = 16'd10000;
  localparam logic [22:0] MIN_RANGE_RST     = 23'd20000;
  localparam logic [22:0] MAX_RANGE_RST     = 23'd4000000;

  typedef enum logic [2:0] {
    REG_TRIGGER_WIDTH = 3'd0,
    REG_SETTLE_LIMIT  = 3'd1,
    REG_START_LIMIT   = 3'd2,
    REG_ECHO_LIMIT    = 3'd3,
    REG_GAP_LENGTH    = 3'd4,
    REG_MIN_RANGE     = 3'd5,
    REG_MAX_RANGE     = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    FAIL_NONE        = 2'd0,
    FAIL_STUCK_HIGH  = 2'd1,
    FAIL_NEVER_HIGH  = 2'd2,
    FAIL_RANGE       = 2'd3
  } fail_code_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_SETTLE  = 8'b0000_0010,
    PH_PAUSE   = 8'b0000_0100,
    PH_TLOW    = 8'b0000_1000,
    PH_THIGH   = 8'b0001_0000,
    PH_WAIT    = 8'b0010_0000,
    PH_MEASURE = 8'b0100_0000,
    PH_GAP     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  trigger_width;
    logic [15:0] settle_limit;
    logic [15:0] start_limit;
    logic [15:0] echo_limit;
    logic [15:0] gap_length;
    logic [22:0] min_range_um;
    logic [22:0] max_range_um;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  ok_mask;
    logic        scan_done;
    fail_code_t  fail_code;
    logic [22:0] distance_um;
    logic [1:0]  sensor_index;
    logic        reading_valid;
    logic [3:0]  trigger_levels;
  } result_t;

endpackage

>>> rtl/core/urs_cfg_regs.sv
// ----------------------------------------------------------------------------
// urs_cfg_regs
// Configuration register bank written through an indexed write channel.
// ----------------------------------------------------------------------------
module urs_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [22:0]   cfg_data,
  output urs_pkg::cfg_t cfg
);
  import urs_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width <= TRIGGER_WIDTH_RST;
      cfg.settle_limit  <= SETTLE_LIMIT_RST;
      cfg.start_limit   <= START_LIMIT_RST;
      cfg.echo_limit    <= ECHO_LIMIT_RST;
      cfg.gap_length    <= GAP_LENGTH_RST;
      cfg.min_range_um  <= MIN_RANGE_RST;
      cfg.max_range_um  <= MAX_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRIGGER_WIDTH: cfg.trigger_width <= cfg_data[7:0];
        REG_SETTLE_LIMIT:  cfg.settle_limit  <= cfg_data[15:0];
        REG_START_LIMIT:   cfg.start_limit   <= cfg_data[15:0];
        REG_ECHO_LIMIT:    cfg.echo_limit    <= cfg_data[15:0];
        REG_GAP_LENGTH:    cfg.gap_length    <= cfg_data[15:0];
        REG_MIN_RANGE:     cfg.min_range_um  <= cfg_data;
        REG_MAX_RANGE:     cfg.max_range_um  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/urs_range_calc.sv
// ----------------------------------------------------------------------------
// urs_range_calc
// Converts an echo width in ticks to micrometres and checks the window.
// ----------------------------------------------------------------------------
module urs_range_calc (
  input  logic [16:0] ticks,
  input  logic [22:0] min_range_um,
  input  logic [22:0] max_range_um,
  output logic [22:0] distance_um,
  output logic        in_range
);
  import urs_pkg::*;

  logic [25:0] twice;
  logic [25:0] lower;
  logic [25:0] upper;

  assign twice       = 26'(ticks * SOUND_NUM);
  assign lower       = {2'b00, min_range_um, 1'b0};
  assign upper       = {2'b00, max_range_um, 1'b0};
  assign in_range    = (twice >= lower) && (twice <= upper);
  assign distance_um = twice[23:1];

endmodule

>>> rtl/core/urs_sequencer.sv
// ----------------------------------------------------------------------------
// urs_sequencer
// Per-tick scan state machine: settle, pause, trigger, wait, measure, gap.
// ----------------------------------------------------------------------------
module urs_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             start_scan,
  input  logic [3:0]       echo_levels,
  input  urs_pkg::cfg_t    cfg,
  output urs_pkg::result_t result
);
  import urs_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [16:0] tick_count;
  logic [16:0] tick_count_next;
  logic [1:0]  current_sensor;
  logic [1:0]  current_sensor_next;
  logic [3:0]  good_mask;
  logic [3:0]  good_mask_next;

  logic        echo;
  logic [16:0] tick_inc;
  logic [7:0]  width;
  logic [22:0] calc_distance;
  logic        calc_in_range;
  logic        finish;
  logic        advance;

  urs_range_calc u_range (
    .ticks        (tick_count),
    .min_range_um (cfg.min_range_um),
    .max_range_um (cfg.max_range_um),
    .distance_um  (calc_distance),
    .in_range     (calc_in_range)
  );

  assign echo     = echo_levels[current_sensor];
  assign tick_inc = tick_count + 17'd1;
  assign width    = (cfg.trigger_width == 8'd0) ? 8'd1 : cfg.trigger_width;

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    current_sensor_next = current_sensor;
    good_mask_next      = good_mask;
    finish              = 1'b0;
    advance             = 1'b0;
    result              = '0;
    result.fail_code    = FAIL_NONE;

    case (phase)
      PH_IDLE: begin
        if (start_scan) begin
          good_mask_next      = 4'd0;
          current_sensor_next = 2'd0;
          tick_count_next     = 17'd0;
          phase_next          = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (!echo) begin
          phase_next      = PH_PAUSE;
          tick_count_next = 17'd0;
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc > {1'b0, cfg.settle_limit}) begin
            result.reading_valid = 1'b1;
            result.fail_code     = FAIL_STUCK_HIGH;
            finish               = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        tick_count_next = tick_inc;
        if (tick_inc >= PAUSE_TICKS) begin
          phase_next      = PH_TLOW;
          tick_count_next = 17'd0;
        end
      end
      PH_TLOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= TRIG_LOW_TICKS) begin
          phase_next      = PH_THIGH;
          tick_count_next = 17'd0;
        end
      end
      PH_THIGH: begin
        result.trigger_levels = 4'b0001 << current_sensor;
        tick_count_next       = tick_inc;
        if (tick_inc >= {9'd0, width}) begin
          phase_next      = PH_WAIT;
          tick_count_next = 17'd0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_next      = PH_MEASURE;
          tick_count_next = 17'd1;
          if (cfg.echo_limit == 16'd0) begin
            result.reading_valid = 1'b1;
            result.fail_code     = FAIL_RANGE;
            finish               = 1'b1;
          end
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc > {1'b0, cfg.start_limit}) begin
            result.reading_valid = 1'b1;
            result.fail_code     = FAIL_NEVER_HIGH;
            finish               = 1'b1;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          tick_count_next = tick_inc;
          if (tick_inc > {1'b0, cfg.echo_limit}) begin
            result.reading_valid = 1'b1;
            result.fail_code     = FAIL_RANGE;
            finish               = 1'b1;
          end
        end else begin
          result.reading_valid = 1'b1;
          finish               = 1'b1;
          if (calc_in_range) begin
            result.distance_um = calc_distance;
            good_mask_next     = good_mask | (4'b0001 << current_sensor);
          end else begin
            result.fail_code = FAIL_RANGE;
          end
        end
      end
      PH_GAP: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {1'b0, cfg.gap_length}) begin
          advance = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (finish) begin
      tick_count_next = 17'd0;
      if (cfg.gap_length == 16'd0) begin
        advance = 1'b1;
      end else begin
        phase_next = PH_GAP;
      end
    end

    if (advance) begin
      tick_count_next = 17'd0;
      if (current_sensor == LAST_SENSOR) begin
        phase_next       = PH_IDLE;
        result.scan_done = 1'b1;
      end else begin
        current_sensor_next = current_sensor + 2'd1;
        phase_next          = PH_SETTLE;
      end
    end

    if (result.reading_valid) begin
      result.sensor_index = current_sensor;
    end
    result.ok_mask = good_mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= 17'd0;
      current_sensor <= 2'd0;
      good_mask      <= 4'd0;
    end else if (step) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      current_sensor <= current_sensor_next;
      good_mask      <= good_mask_next;
    end
  end

endmodule

>>> rtl/core/ultrasonic_ranger_sequencer.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_sequencer
// Scans four echo-ranging sensors one at a time, one input word per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         one tick: start request and sampled echo lines
// m_axis    out        one result word per tick: triggers, reading, mask
// cfg       in         register index and write data
//
// Each result word is held in the input register and then in the result
// register before it is on m_axis; a new word is taken every cycle while
// m_axis is not stalled.
// Reset clears the scan state, the pipeline and the configuration registers.
// A stall on m_axis holds the result register and backs up into s_axis.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // start_scan, echo_levels[4], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // trigger_levels[4], reading_valid, sensor_index[2], distance_um[23],
  // fail_code[2], scan_done, ok_mask[4], zero pad
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  import urs_pkg::*;

  cfg_t       cfg;
  result_t    result;
  result_t    out_word;
  logic       in_full;
  logic       in_start;
  logic [3:0] in_echo;
  logic       step;

  urs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign step          = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start <= s_axis_tdata[0];
      in_echo  <= s_axis_tdata[4:1];
    end
  end

  urs_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .start_scan  (in_start),
    .echo_levels (in_echo),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = {3'b000, out_word};

endmodule
